/* rtl/core/ordered_software_timer_queue_unit_defines.svh */
// assertion macros used by the checker file
`ifndef ORDERED_SOFTWARE_TIMER_QUEUE_UNIT_DEFINES_SVH
`define ORDERED_SOFTWARE_TIMER_QUEUE_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define OTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold across reset
`define OTQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/otq_pkg.sv */
package otq_pkg;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned DELAY_W = 31;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // defaults
  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam logic [TICK_W-1:0] TICK_RESET = 16'd20;

  // request kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_CANCEL = 2'd2
  } otq_cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_FLUSH,
    ST_UNL_WALK,
    ST_UNL_STEP,
    ST_INS_WALK,
    ST_INS_STEP,
    ST_INS_WR1,
    ST_INS_WR2
  } otq_state_t;

  // one expiry result
  typedef struct packed {
    logic [ID_W-1:0] timer;
    logic            last;
  } otq_res_t;

  // true when time a is not later than time b, wrap-safe
  function automatic logic time_le(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = b - a;
    return !diff[TIME_W-1];
  endfunction

endpackage

/* rtl/core/otq_ram.sv */
module otq_ram import otq_pkg::*; #(
  parameter int WIDTH = TIME_W,
  parameter int DEPTH = NUM_TIMERS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/otq_obuf.sv */
module otq_obuf import otq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  otq_res_t push_res,
  output logic     push_ready,
  output logic     res_valid,
  input  logic     res_ready,
  output otq_res_t res
);

  logic     valid_r;
  otq_res_t res_r;

  assign push_ready = !valid_r || res_ready;
  assign res_valid  = valid_r;
  assign res        = res_r;

  // output register, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_valid) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      res_r <= push_res;
    end
  end

endmodule

/* rtl/core/otq_seq.sv */
module otq_seq import otq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  localparam int IW = $clog2(NUM_TIMERS),
  localparam int LW = $clog2(NUM_TIMERS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [TICK_W-1:0]  cfg_wdata,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [CMD_W-1:0]   req_cmd,
  input  logic [ID_W-1:0]    req_id,
  input  logic [DELAY_W-1:0] req_delay,
  output logic               rd_en,
  output logic [IW-1:0]      rd_addr,
  input  logic [TIME_W-1:0]  dl_rdata,
  input  logic [LW-1:0]      lk_rdata,
  output logic               dl_we,
  output logic [IW-1:0]      dl_waddr,
  output logic [TIME_W-1:0]  dl_wdata,
  output logic               lk_we,
  output logic [IW-1:0]      lk_waddr,
  output logic [LW-1:0]      lk_wdata,
  input  logic               push_ready,
  output logic               push_valid,
  output otq_res_t           push_res
);

  localparam logic [LW-1:0] LINK_NONE = LW'(NUM_TIMERS);

  otq_state_t         state_r, state_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TICK_W-1:0]  tick_r;
  logic [LW-1:0]      head_r, head_nxt;
  logic [LW-1:0]      cur_r, cur_nxt;
  logic [LW-1:0]      prev_r, prev_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic [TIME_W-1:0]  when_r, when_nxt;
  logic               is_set_r, is_set_nxt;
  logic [IW-1:0]      pend_r, pend_nxt;
  logic               has_pend_r, has_pend_nxt;
  logic               armed_r [NUM_TIMERS];

  logic               arm_we;
  logic               arm_val;
  logic [IW-1:0]      arm_idx;
  logic [IW-1:0]      req_slot;
  logic               id_ok;
  logic [IW-1:0]      head_idx;

  assign req_slot = IW'(req_id);
  assign id_ok    = (32'(req_id) < NUM_TIMERS);
  assign head_idx = head_r[IW-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      now_r      <= '0;
      tick_r     <= TICK_RESET;
      head_r     <= LINK_NONE;
      has_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      now_r      <= now_nxt;
      head_r     <= head_nxt;
      has_pend_r <= has_pend_nxt;
      if (cfg_we) begin
        tick_r <= cfg_wdata;
      end
    end
  end

  // walk pointers and held request fields
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    slot_r   <= slot_nxt;
    when_r   <= when_nxt;
    is_set_r <= is_set_nxt;
    pend_r   <= pend_nxt;
  end

  // armed flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed_r[i] <= 1'b0;
      end
    end else if (arm_we) begin
      armed_r[arm_idx] <= arm_val;
    end
  end

  // sequencer: one memory access in flight at a time
  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    head_nxt     = head_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    slot_nxt     = slot_r;
    when_nxt     = when_r;
    is_set_nxt   = is_set_r;
    pend_nxt     = pend_r;
    has_pend_nxt = has_pend_r;
    arm_we       = 1'b0;
    arm_val      = 1'b0;
    arm_idx      = slot_r;
    rd_en        = 1'b0;
    rd_addr      = cur_r[IW-1:0];
    dl_we        = 1'b0;
    dl_waddr     = slot_r;
    dl_wdata     = when_r;
    lk_we        = 1'b0;
    lk_waddr     = slot_r;
    lk_wdata     = cur_r;
    push_valid   = 1'b0;
    push_res     = '{timer: ID_W'(pend_r), last: 1'b0};
    req_ready    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (otq_cmd_t'(req_cmd))
            CMD_TICK: begin
              now_nxt   = now_r + TIME_W'(tick_r);
              state_nxt = ST_TICK_RD;
            end
            CMD_SET: begin
              if (id_ok) begin
                slot_nxt   = req_slot;
                when_nxt   = now_r + TIME_W'(req_delay);
                is_set_nxt = 1'b1;
                cur_nxt    = head_r;
                prev_nxt   = LINK_NONE;
                state_nxt  = armed_r[req_slot] ? ST_UNL_WALK : ST_INS_WALK;
              end
            end
            CMD_CANCEL: begin
              if (id_ok && armed_r[req_slot]) begin
                slot_nxt   = req_slot;
                is_set_nxt = 1'b0;
                cur_nxt    = head_r;
                prev_nxt   = LINK_NONE;
                state_nxt  = ST_UNL_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      // fetch the list head for the expiry check
      ST_TICK_RD: begin
        if (head_r == LINK_NONE || !armed_r[head_idx]) begin
          state_nxt = ST_TICK_FLUSH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_idx;
          state_nxt = ST_TICK_CHK;
        end
      end

      // head expired: release the held result, hold this one until the next check
      ST_TICK_CHK: begin
        if (time_le(dl_rdata, now_r)) begin
          if (!has_pend_r || push_ready) begin
            push_valid   = has_pend_r;
            pend_nxt     = head_idx;
            has_pend_nxt = 1'b1;
            head_nxt     = lk_rdata;
            arm_we       = 1'b1;
            arm_val      = 1'b0;
            arm_idx      = head_idx;
            state_nxt    = ST_TICK_RD;
          end
        end else begin
          state_nxt = ST_TICK_FLUSH;
        end
      end

      // final result of the run carries the last flag
      ST_TICK_FLUSH: begin
        if (!has_pend_r) begin
          state_nxt = ST_IDLE;
        end else if (push_ready) begin
          push_valid   = 1'b1;
          push_res     = '{timer: ID_W'(pend_r), last: 1'b1};
          has_pend_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      // search for the slot to unlink
      ST_UNL_WALK: begin
        if (cur_r == LINK_NONE) begin
          arm_we    = 1'b1;
          arm_val   = 1'b0;
          cur_nxt   = head_r;
          prev_nxt  = LINK_NONE;
          state_nxt = is_set_r ? ST_INS_WALK : ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_UNL_STEP;
        end
      end

      ST_UNL_STEP: begin
        if (cur_r == LW'(slot_r)) begin
          // splice the successor into the predecessor or the head
          if (prev_r != LINK_NONE) begin
            lk_we    = 1'b1;
            lk_waddr = prev_r[IW-1:0];
            lk_wdata = lk_rdata;
            cur_nxt  = head_r;
          end else begin
            head_nxt = lk_rdata;
            cur_nxt  = lk_rdata;
          end
          prev_nxt  = LINK_NONE;
          arm_we    = 1'b1;
          arm_val   = 1'b0;
          state_nxt = is_set_r ? ST_INS_WALK : ST_IDLE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lk_rdata;
          state_nxt = ST_UNL_WALK;
        end
      end

      // search for the first later deadline
      ST_INS_WALK: begin
        if (cur_r == LINK_NONE) begin
          state_nxt = ST_INS_WR1;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_INS_STEP;
        end
      end

      ST_INS_STEP: begin
        if (time_le(dl_rdata, when_r)) begin
          prev_nxt  = cur_r;
          cur_nxt   = lk_rdata;
          state_nxt = ST_INS_WALK;
        end else begin
          state_nxt = ST_INS_WR1;
        end
      end

      // new entry points at the later neighbour
      ST_INS_WR1: begin
        dl_we     = 1'b1;
        lk_we     = 1'b1;
        state_nxt = ST_INS_WR2;
      end

      // predecessor or head points at the new entry
      ST_INS_WR2: begin
        if (prev_r != LINK_NONE) begin
          lk_we    = 1'b1;
          lk_waddr = prev_r[IW-1:0];
          lk_wdata = LW'(slot_r);
        end else begin
          head_nxt = LW'(slot_r);
        end
        arm_we    = 1'b1;
        arm_val   = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/ordered_software_timer_queue_unit.sv */
// Ordered timer queue: NUM_TIMERS slots kept in one linked list sorted by
// deadline, with deadlines and links held in two single-port-write RAMs with
// registered reads and the armed flags in flip-flops cleared by reset, so no
// clearing pass is needed. Requests are taken one at a time; in_tready is high
// only when the previous request is finished. Every RAM access is a read,
// then a step that acts on the data. A set first walks the list to unlink the
// old entry if the slot is armed, then walks it to find the insert point and
// links the entry in; a cancel of an armed slot walks the list to unlink. A
// tick checks the head for each expired timer, then flushes the run, and waits
// while the result side stalls. Expiries leave in list order, one per request
// on the out_ side, and the last of a tick carries tlast. tick_interval is
// written through cfg_we and cfg_wdata; the user must write it only while
// idle, as the block itself does not enforce this.
module ordered_software_timer_queue_unit import otq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [TICK_W-1:0]     cfg_wdata,    // tick_interval
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,     // timer_id[3:0], delay[34:4], zero[39:35]
  input  logic [CMD_W-1:0]      in_tuser,     // command[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // expired_timer[3:0], zero[7:4]
  output logic                  out_tlast     // last_of_run
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [TIME_W-1:0] dl_rdata;
  logic [LW-1:0]     lk_rdata;
  logic              dl_we;
  logic [IW-1:0]     dl_waddr;
  logic [TIME_W-1:0] dl_wdata;
  logic              lk_we;
  logic [IW-1:0]     lk_waddr;
  logic [LW-1:0]     lk_wdata;
  logic              push_ready;
  logic              push_valid;
  otq_res_t          push_res;
  otq_res_t          res;

  // list sequencer
  otq_seq #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_cmd    (in_tuser),
    .req_id     (in_tdata[ID_W-1:0]),
    .req_delay  (in_tdata[ID_W+DELAY_W-1:ID_W]),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .dl_rdata   (dl_rdata),
    .lk_rdata   (lk_rdata),
    .dl_we      (dl_we),
    .dl_waddr   (dl_waddr),
    .dl_wdata   (dl_wdata),
    .lk_we      (lk_we),
    .lk_waddr   (lk_waddr),
    .lk_wdata   (lk_wdata),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_res   (push_res)
  );

  // deadline store
  otq_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_TIMERS)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (dl_rdata)
  );

  // next-link store
  otq_ram #(
    .WIDTH(LW),
    .DEPTH(NUM_TIMERS)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lk_rdata)
  );

  // result register
  otq_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_res   (push_res),
    .push_ready (push_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {(OUT_DATA_W - ID_W)'(0), res.timer};
  assign out_tlast = res.last;

endmodule

/* rtl/core/otq_checker.sv */
`include "ordered_software_timer_queue_unit_defines.svh"

module otq_checker import otq_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a stalled result holds
  `OTQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // set, cancel and unknown requests never produce a result
  `OTQ_ASSERT(a_no_result, in_tvalid && in_tready && in_tuser != CMD_TICK && !out_tvalid |=> !out_tvalid, "result without a tick")

  // a tick is never finished in the cycle it is accepted
  `OTQ_ASSERT(a_tick_busy, in_tvalid && in_tready && in_tuser == CMD_TICK |=> !in_tready, "tick finished at once")

  // reset leaves the block empty and ready
  `OTQ_ASSERT_RST(a_reset_state, !rst_n |=> !out_tvalid && in_tready, "bad state after reset")

endmodule

bind ordered_software_timer_queue_unit otq_checker u_otq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* verif/ordered_software_timer_queue_unit_tb.sv */
module ordered_software_timer_queue_unit_tb import otq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS       = NUM_TIMERS_DEF;
  localparam logic [4:0]  NO_SLOT     = 5'd16;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam int          SETTLE      = 4 * SLOTS + 16;
  localparam int          STALL_LIMIT = 3000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [TICK_W-1:0]     cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // timer_id[3:0], delay[34:4], zero[39:35]
  logic [CMD_W-1:0]      in_tuser   = '0;   // command[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // expired_timer[3:0], zero[7:4]
  logic                  out_tlast;

  // shared run state
  bit quiet        = 1'b0;
  int fails        = 0;
  int idle_cycles  = 0;

  // own copy of the timer list
  logic [TICK_W-1:0] tq_tick;
  logic [31:0]       tq_now;
  logic [31:0]       tq_deadline [SLOTS];
  logic              tq_armed    [SLOTS];
  logic [4:0]        tq_next     [SLOTS];
  logic [4:0]        tq_head;

  // expiries still to come out of the block
  otq_res_t expiry_q [$];

  ordered_software_timer_queue_unit #(.NUM_TIMERS(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // a is not later than b, with wrap
  function automatic bit not_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = b - a;
    return (diff & SIGN_BIT) == 32'd0;
  endfunction

  function automatic void list_clear();
    tq_tick = TICK_RESET;
    tq_now  = '0;
    tq_head = NO_SLOT;
    for (int i = 0; i < SLOTS; i++) begin
      tq_deadline[i] = '0;
      tq_armed[i]    = 1'b0;
      tq_next[i]     = '0;
    end
  endfunction

  // take a slot out of the list and disarm it
  function automatic void drop_slot(int slot);
    logic [4:0] prev;
    logic [4:0] cur;
    int steps;
    prev  = NO_SLOT;
    cur   = tq_head;
    steps = 0;
    while (cur < SLOTS && cur != slot && steps < SLOTS) begin
      prev = cur;
      cur  = tq_next[cur];
      steps++;
    end
    if (cur == slot) begin
      if (prev < SLOTS) tq_next[prev] = tq_next[slot];
      else tq_head = tq_next[slot];
    end
    tq_armed[slot] = 1'b0;
  endfunction

  // insert behind every timer due at the same time or earlier
  function automatic void place_slot(int slot, logic [31:0] due);
    logic [4:0] prev;
    logic [4:0] cur;
    int steps;
    prev  = NO_SLOT;
    cur   = tq_head;
    steps = 0;
    while (cur < SLOTS && steps < SLOTS && not_later(tq_deadline[cur], due)) begin
      prev = cur;
      cur  = tq_next[cur];
      steps++;
    end
    tq_deadline[slot] = due;
    tq_next[slot]     = (cur < SLOTS) ? cur : NO_SLOT;
    if (prev < SLOTS) tq_next[prev] = 5'(slot);
    else tq_head = 5'(slot);
    tq_armed[slot] = 1'b1;
  endfunction

  // update the list for one accepted request and queue its expiries
  function automatic void predict_request(logic [1:0] cmd, logic [3:0] id, logic [30:0] dly);
    otq_res_t run [$];
    otq_res_t one;
    logic [4:0] t;
    case (cmd)
      CMD_TICK: begin
        tq_now = tq_now + 32'(tq_tick);
        while (tq_head < SLOTS && run.size() < SLOTS) begin
          t = tq_head;
          if (!tq_armed[t] || !not_later(tq_deadline[t], tq_now)) break;
          tq_head     = tq_next[t];
          tq_armed[t] = 1'b0;
          one.timer   = t[3:0];
          one.last    = 1'b0;
          run.push_back(one);
        end
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[i]) expiry_q.push_back(run[i]);
      end
      CMD_SET: begin
        if (tq_armed[id]) drop_slot(id);
        place_slot(id, tq_now + {1'b0, dly});
      end
      CMD_CANCEL: begin
        if (tq_armed[id]) drop_slot(id);
      end
      default: ;
    endcase
  endfunction

  // send one request, with an optional gap ahead of it
  task automatic send_request(input logic [1:0] cmd, input logic [3:0] id,
                              input logic [30:0] dly);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, dly, id};
    do @(posedge clk); while (!in_tready);
    predict_request(cmd, id, dly);
  endtask

  // let the block finish everything before touching the register
  task automatic wait_drained();
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tick_interval(input logic [TICK_W-1:0] value);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    tq_tick = value;
  endtask

  // reset interval: empty tick, ordering, re-arm, cancel, unknown command
  task automatic test_basic_list();
    send_request(CMD_TICK, 4'd0, 31'd0);
    send_request(CMD_SET, 4'd0, 31'd0);
    send_request(CMD_SET, 4'd1, 31'h7FFF_FFFF);
    send_request(CMD_SET, 4'd2, 31'd30);
    send_request(CMD_SET, 4'd3, 31'd30);
    send_request(CMD_SET, 4'd4, 31'd10);
    send_request(CMD_CANCEL, 4'd5, 31'd0);
    send_request(CMD_CANCEL, 4'd4, 31'h7FFF_FFFF);
    send_request(CMD_SET, 4'd2, 31'd5);
    send_request(CMD_UNKNOWN, 4'd15, 31'h7FFF_FFFF);
    send_request(CMD_TICK, 4'd15, 31'h7FFF_FFFF);
    send_request(CMD_TICK, 4'd0, 31'd0);
    send_request(CMD_SET, 4'd15, 31'd0);
    send_request(CMD_CANCEL, 4'd15, 31'd0);
    send_request(CMD_TICK, 4'd0, 31'd0);
  endtask

  // zero and largest tick interval
  task automatic test_interval_extremes();
    write_tick_interval(16'd0);
    send_request(CMD_SET, 4'd7, 31'd0);
    send_request(CMD_TICK, 4'd0, 31'd0);
    send_request(CMD_TICK, 4'd0, 31'd0);
    write_tick_interval(16'hFFFF);
    send_request(CMD_SET, 4'd8, 31'd65535);
    send_request(CMD_SET, 4'd9, 31'd65536);
    send_request(CMD_TICK, 4'd0, 31'd0);
    send_request(CMD_TICK, 4'd0, 31'd0);
  endtask

  // every slot armed, one tick expires them all
  task automatic test_full_pool();
    logic [30:0] dly;
    write_tick_interval(16'd1000);
    for (int i = 0; i < SLOTS; i++) begin
      dly = 31'($urandom_range(0, 999));
      send_request(CMD_SET, 4'(i), dly);
    end
    send_request(CMD_TICK, 4'd0, 31'd0);
  endtask

  // mostly sets with near deadlines and ticks, with some noise
  task automatic test_random_traffic(input int count);
    int n;
    int pick;
    int span;
    logic [1:0]  cmd;
    logic [3:0]  id;
    logic [30:0] dly;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      id   = 4'($urandom_range(0, SLOTS - 1));
      span = (tq_tick == 0) ? 4 : 3 * int'(tq_tick);
      dly  = 31'($urandom_range(0, span));
      if (pick < 50) cmd = CMD_SET;
      else if (pick < 58) begin
        cmd = CMD_SET;
        dly = 31'($urandom);
      end else if (pick < 82) cmd = CMD_TICK;
      else if (pick < 95) cmd = CMD_CANCEL;
      else cmd = CMD_UNKNOWN;
      // unused fields still toggle
      if (cmd != CMD_SET && $urandom_range(0, 1) == 0) dly = 31'($urandom);
      send_request(cmd, id, dly);
      n++;
    end
  endtask

  // result side stalls in bursts
  always @(posedge clk) begin : ready_gen
    int hold;
    if (quiet) out_tready <= 1'b1;
    else if (hold == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        hold = $urandom_range(1, 7);
      end else begin
        out_tready <= 1'b1;
        hold = $urandom_range(1, 12);
      end
    end else hold--;
  end

  // compare each expiry with the oldest one predicted
  always @(posedge clk) begin : expiry_check
    otq_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expiry_q.size() == 0) begin
        $display("%0t: unexpected expiry: expected none, actual timer %0d last %0b",
                 $time, out_tdata[3:0], out_tlast);
        fails++;
      end else begin
        want = expiry_q.pop_front();
        if (out_tdata[3:0] !== want.timer) begin
          $display("%0t: expired_timer mismatch: expected %0d, actual %0d",
                   $time, want.timer, out_tdata[3:0]);
          fails++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                   $time, want.last, out_tlast);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("ordered_software_timer_queue_unit regression: fail");
      $finish;
    end
  end

  initial begin
    list_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_list();
    test_interval_extremes();
    test_full_pool();
    write_tick_interval(16'($urandom_range(1, 200)));
    test_random_traffic(30);
    write_tick_interval(16'd1);
    test_random_traffic(30);
    write_tick_interval(16'd20);
    quiet = 1'b1;
    test_random_traffic(30);

    in_tvalid <= 1'b0;
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) $display("ordered_software_timer_queue_unit regression: pass");
    else $display("ordered_software_timer_queue_unit regression: fail");
    $finish;
  end

endmodule
